// ===== rtl/eat_pkg.sv =====
// Shared types and character constants for the escape-aware tokenizer.
package eat_pkg;

	localparam int unsigned EAT_QDEPTH = 4;
	localparam int unsigned EAT_QAW    = $clog2(EAT_QDEPTH);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_V   = 8'h76;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG7   = 8'h37;

	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_OCT    = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] accum;
		logic [1:0] digits;
		logic       in_token;
		logic       nonempty;
	} state_t;

	typedef struct packed {
		logic [7:0] value;
		logic       token_end;
		logic       last;
	} result_t;

	// Up to two result words produced by one input character.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== rtl/eat_step.sv =====
// Next-state and result decode for one input character.
module eat_step (
	input  logic [7:0]      ch,
	input  eat_pkg::state_t cur,
	output eat_pkg::state_t nxt,
	output eat_pkg::push_t  push
);
	import eat_pkg::*;

	logic       is_ws;
	logic       is_oct;
	logic       nrm_en;
	logic [7:0] esc_val;
	logic       a_en;
	logic [7:0] a_val;
	logic       b_en;
	logic       b_end;
	logic [7:0] b_val;
	result_t    ra;
	result_t    rb;

	assign is_ws  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_oct = (ch >= CH_DIG0) && (ch <= CH_DIG7);
	assign nrm_en = (ch != CH_BSLASH);

	always_comb begin
		unique case (ch)
			CH_LO_N: esc_val = CH_LF;
			CH_LO_R: esc_val = CH_CR;
			CH_LO_T: esc_val = CH_TAB;
			CH_LO_V: esc_val = CH_VT;
			CH_LO_F: esc_val = CH_FF;
			default: esc_val = ch;
		endcase
	end

	always_comb begin
		nxt   = cur;
		a_en  = 1'b0;
		a_val = cur.accum;
		b_en  = 1'b0;
		b_end = 1'b0;
		b_val = ch;
		if (ch == CH_NUL) begin
			// end of message: flush octal, close token, clear all
			a_en  = cur.in_token && (cur.mode == MODE_OCT);
			b_en  = cur.in_token && (cur.nonempty || (cur.mode == MODE_OCT));
			b_end = 1'b1;
			nxt   = '{mode: MODE_NORMAL, accum: '0, digits: '0, in_token: 1'b0,
				nonempty: 1'b0};
		end else if (!cur.in_token) begin
			if (!is_ws) begin
				nxt.in_token = 1'b1;
				nxt.nonempty = nrm_en;
				nxt.mode     = nrm_en ? MODE_NORMAL : MODE_ESC;
				b_en         = nrm_en;
			end
		end else begin
			unique case (cur.mode)
				MODE_ESC: begin
					if (is_oct) begin
						nxt.mode   = MODE_OCT;
						nxt.accum  = {5'd0, ch[2:0]};
						nxt.digits = 2'd1;
					end else begin
						b_en         = 1'b1;
						b_val        = esc_val;
						nxt.nonempty = 1'b1;
						nxt.mode     = MODE_NORMAL;
					end
				end
				MODE_OCT: begin
					if (!is_oct || (cur.digits >= OCT_MAX_DIGITS)) begin
						// terminator flushes the byte, then is handled normally
						a_en         = 1'b1;
						nxt.nonempty = 1'b1;
						nxt.mode     = nrm_en ? MODE_NORMAL : MODE_ESC;
						b_en         = nrm_en;
						b_end        = is_ws;
						if (is_ws) begin
							nxt.in_token = 1'b0;
							nxt.nonempty = 1'b0;
						end
					end else begin
						nxt.accum  = {cur.accum[4:0], ch[2:0]};
						nxt.digits = cur.digits + 2'd1;
					end
				end
				default: begin
					nxt.mode = nrm_en ? MODE_NORMAL : MODE_ESC;
					b_en     = nrm_en;
					b_end    = is_ws;
					if (is_ws) begin
						nxt.in_token = 1'b0;
						nxt.nonempty = 1'b0;
					end else if (nrm_en) begin
						nxt.nonempty = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		ra = '{value: a_val, token_end: 1'b0, last: !b_en};
		rb = '{value: b_end ? 8'd0 : b_val, token_end: b_end, last: 1'b1};
		push.n  = {1'b0, a_en} + {1'b0, b_en};
		push.r0 = a_en ? ra : rb;
		push.r1 = rb;
	end

endmodule

// ===== rtl/eat_queue.sv =====
// Result queue: takes up to two words per cycle, hands out one.
module eat_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  eat_pkg::push_t    push,
	input  logic              pop,
	output eat_pkg::result_t head,
	output logic              has_room,
	output logic              not_empty
);
	import eat_pkg::*;

	result_t           mem_q [EAT_QDEPTH];
	logic [EAT_QAW-1:0] wp_q;
	logic [EAT_QAW-1:0] rp_q;
	logic [EAT_QAW:0]   cnt_q;
	logic [EAT_QAW-1:0] wp1;

	assign wp1       = wp_q + 1'b1;
	assign head      = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign has_room  = (cnt_q <= (EAT_QAW+1)'(EAT_QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + EAT_QAW'(push.n);
			rp_q  <= rp_q + EAT_QAW'(pop);
			cnt_q <= cnt_q + (EAT_QAW+1)'(push.n) - (EAT_QAW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (EAT_QAW+1)'(EAT_QDEPTH)) else $error("queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> has_room) else $error("push without room");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");

endmodule

// ===== rtl/escape_aware_tokenizer.sv =====
// Top level of the escape-aware command-line tokenizer.
//
//  channel | signals                           | dir | word
//  --------+-----------------------------------+-----+------------------------------
//  in      | in_valid, in_stall, ch            | in  | one message character
//  out     | out_valid, out_stall, value,      | out | one token byte or token end
//          | token_end, last                   |     |
//
// One character is taken per cycle while in_stall is low; its decode is a single
// combinational pass from the tokenizer state into a 4-word result queue, so the state is
// ready for the next character at the next edge.
// A character gives zero, one or two words; the output drains one per cycle while out_stall
// is low, so sustained rate is one character per cycle unless characters average
// more than one word (octal terminators, end of message).
// in_stall rises when the queue has fewer than two free slots.
// arst_n clears the tokenizer state and empties the queue; no clearing pass.
// Words at the head of the queue hold while out_stall is high.
module escape_aware_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] value,
	output logic       token_end,
	output logic       last
);
	import eat_pkg::*;

	state_t  state_q;
	state_t  state_nxt;
	push_t   step_push;
	push_t   q_push;
	result_t head;
	logic    has_room;
	logic    in_acc;
	logic    out_acc;

	assign in_stall = !has_room;
	assign in_acc   = in_valid && has_room;
	assign out_acc  = out_valid && !out_stall;

	// decode of the current character against the registered state
	eat_step u_step (
		.ch   (ch),
		.cur  (state_q),
		.nxt  (state_nxt),
		.push (step_push)
	);

	// only accepted characters push words
	always_comb begin
		q_push   = step_push;
		q_push.n = in_acc ? step_push.n : 2'd0;
	end

	eat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.pop       (out_acc),
		.head      (head),
		.has_room  (has_room),
		.not_empty (out_valid)
	);

	assign value     = head.value;
	assign token_end = head.token_end;
	assign last      = head.last;

	// tokenizer state: escape mode, octal accumulator, token flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_NORMAL, accum: '0, digits: '0, in_token: 1'b0,
				nonempty: 1'b0};
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	a_eom_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (ch == CH_NUL)) |=> ((state_q.mode == MODE_NORMAL) &&
		!state_q.in_token && !state_q.nonempty))
		else $error("state not cleared after end of message");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (step_push.n == 2'd2)) |-> (!step_push.r0.last &&
		step_push.r1.last)) else $error("last mark misplaced on word pair");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (step_push.n == 2'd1)) |-> step_push.r0.last)
		else $error("single word lacks last mark");
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_end) |-> (value == 8'd0))
		else $error("token end carries nonzero byte");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the escape-aware tokenizer: directed script, random traffic.
module testbench;
	import eat_pkg::*;

	localparam int      PREDICT    = -1;    // script row is checked against the model
	localparam int      IDLE_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int      RANDOM_CHARS = 1400;
	localparam int      HOLD_CYCLES  = 64;  // one long receiver hold-off
	localparam result_t NIL        = '0;

	typedef struct {
		logic [7:0] ch;
		int         typed_n;  // PREDICT, or number of typed words below
		result_t    w0;
		result_t    w1;
	} stim_row_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] ch        = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] value;
	logic       token_end;
	logic       last;

	// Typed expectation rides along with ch, driven with it and sampled at the same edge.
	int         row_typed_n = PREDICT;
	result_t    row_w0      = NIL;
	result_t    row_w1      = NIL;

	// Tokenizer shadow state.
	mode_t      tk_mode     = MODE_NORMAL;
	logic [7:0] tk_accum    = 8'h00;
	logic [1:0] tk_digits   = 2'd0;
	logic       tk_inside   = 1'b0;
	logic       tk_nonempty = 1'b0;

	result_t    step_words[$];     // words produced by the current character
	result_t    owed_words[$];     // words the block still has to deliver
	result_t    got;
	int         errors      = 0;
	int         chars_taken = 0;
	int         idle_cycles = 0;
	int         burst_left  = 0;

	escape_aware_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.token_end (token_end),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Tokenizer prediction
	// ------------------------------------------------------------------

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_octal(logic [7:0] c);
		return c >= CH_DIG0 && c <= CH_DIG7;
	endfunction

	function automatic void add_word(logic [7:0] v, logic ends);
		result_t w;
		w.value     = ends ? 8'h00 : v;
		w.token_end = ends;
		w.last      = 1'b0;
		step_words.push_back(w);
	endfunction

	// Plain (unescaped) character inside a token.
	function automatic void take_plain(logic [7:0] c);
		if (c == CH_BSLASH) begin
			tk_mode = MODE_ESC;
		end else if (is_blank(c)) begin
			add_word(8'h00, 1'b1);
			tk_inside   = 1'b0;
			tk_nonempty = 1'b0;
			tk_mode     = MODE_NORMAL;
		end else begin
			add_word(c, 1'b0);
			tk_nonempty = 1'b1;
		end
	endfunction

	// Advance the shadow state by one character; leaves its words in step_words.
	function automatic void tokenize(logic [7:0] c);
		logic [7:0] v;
		logic [7:0] d;
		step_words.delete();
		d = c - CH_DIG0;
		if (c == CH_NUL) begin
			// end of message: flush octal, close a non-empty token, drop the rest
			if (tk_inside && tk_mode == MODE_OCT) begin
				add_word(tk_accum, 1'b0);
				tk_nonempty = 1'b1;
			end
			if (tk_inside && tk_nonempty)
				add_word(8'h00, 1'b1);
			tk_mode     = MODE_NORMAL;
			tk_accum    = 8'h00;
			tk_digits   = 2'd0;
			tk_inside   = 1'b0;
			tk_nonempty = 1'b0;
		end else if (!tk_inside) begin
			// leading whitespace is skipped
			if (!is_blank(c)) begin
				tk_inside   = 1'b1;
				tk_nonempty = 1'b0;
				tk_mode     = MODE_NORMAL;
				take_plain(c);
			end
		end else if (tk_mode == MODE_ESC) begin
			if (is_octal(c)) begin
				tk_mode   = MODE_OCT;
				tk_accum  = d;
				tk_digits = 2'd1;
			end else begin
				case (c)
					CH_LO_N: v = CH_LF;
					CH_LO_R: v = CH_CR;
					CH_LO_T: v = CH_TAB;
					CH_LO_V: v = CH_VT;
					CH_LO_F: v = CH_FF;
					default: v = c;  // whitespace too: literal here
				endcase
				add_word(v, 1'b0);
				tk_nonempty = 1'b1;
				tk_mode     = MODE_NORMAL;
			end
		end else if (tk_mode == MODE_OCT) begin
			if (!is_octal(c) || tk_digits >= OCT_MAX_DIGITS) begin
				// terminator flushes the byte, then counts as a plain character
				add_word(tk_accum, 1'b0);
				tk_nonempty = 1'b1;
				tk_mode     = MODE_NORMAL;
				take_plain(c);
			end else begin
				tk_accum  = {tk_accum[4:0], d[2:0]};  // overflow keeps the low byte
				tk_digits = tk_digits + 2'd1;
			end
		end else begin
			tk_mode = MODE_NORMAL;
			take_plain(c);
		end
		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: expectations at input accept, compare at output accept.
	// Prediction runs first so a same-edge word would still find its entry.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tokenize(ch);
				chars_taken++;
				if (row_typed_n == PREDICT) begin
					foreach (step_words[i])
						owed_words.push_back(step_words[i]);
				end else begin
					if (row_typed_n > 0)
						owed_words.push_back(row_w0);
					if (row_typed_n > 1)
						owed_words.push_back(row_w1);
				end
			end
			if (out_valid && !out_stall) begin
				got = '{value, token_end, last};
				if (owed_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: value=%02h token_end=%0b last=%0b",
						$time, value, token_end, last);
				end else if (got !== owed_words[0]) begin
					errors++;
					$display("%0t: word mismatch: expected value=%02h token_end=%0b last=%0b, got value=%02h token_end=%0b last=%0b",
						$time, owed_words[0].value, owed_words[0].token_end,
						owed_words[0].last, value, token_end, last);
					void'(owed_words.pop_front());
				end else begin
					void'(owed_words.pop_front());
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Offer one character; burst/gap pacing decided here. Returns after accept.
	task automatic offer(input logic [7:0] c, input int typed_n,
			input result_t w0, input result_t w1);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			// lower valid only for a real gap, never drop and raise in one step
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
				: $urandom_range(1, 30);
		end
		in_valid    <= 1'b1;
		ch          <= c;
		row_typed_n <= typed_n;
		row_w0      <= w0;
		row_w1      <= w1;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// Random character, weighted toward escapes, octal runs and separators.
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 8'($urandom_range(8'h21, 8'hFF));
		if (r < 50)
			return ($urandom_range(0, 2) == 0) ? CH_SPACE
				: 8'($urandom_range(CH_TAB, CH_CR));
		if (r < 65)
			return CH_BSLASH;
		if (r < 80)
			return CH_DIG0 + 8'($urandom_range(0, 7));
		if (r < 88) begin
			case ($urandom_range(0, 4))
				0:       return CH_LO_N;
				1:       return CH_LO_R;
				2:       return CH_LO_T;
				3:       return CH_LO_V;
				default: return CH_LO_F;
			endcase
		end
		if (r < 92)
			return CH_DIG7 + 8'($urandom_range(1, 2));  // '8' or '9': not octal
		if (r < 97)
			return 8'($urandom);
		return CH_NUL;
	endfunction

	// Directed script. Typed words only where obvious; the rest use the predictor.
	stim_row_t script [26] = '{
		'{CH_NUL,    0,       NIL, NIL},                      // NUL right after reset
		'{CH_SPACE,  0,       NIL, NIL},                      // leading blank skipped
		'{8'hFF,     1,       '{8'hFF, 1'b0, 1'b1}, NIL},     // top byte is plain text
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_LO_N,   1,       '{CH_LF, 1'b0, 1'b1}, NIL},
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_LO_R,   1,       '{CH_CR, 1'b0, 1'b1}, NIL},
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_LO_T,   1,       '{CH_TAB, 1'b0, 1'b1}, NIL},
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_LO_V,   1,       '{CH_VT, 1'b0, 1'b1}, NIL},
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_LO_F,   1,       '{CH_FF, 1'b0, 1'b1}, NIL},
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_SPACE,  1,       '{CH_SPACE, 1'b0, 1'b1}, NIL},  // escaped blank is literal
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_DIG7,   PREDICT, NIL, NIL},                      // \777 overflows to 0xFF
		'{CH_DIG7,   PREDICT, NIL, NIL},
		'{CH_DIG7,   PREDICT, NIL, NIL},
		'{CH_DIG7,   PREDICT, NIL, NIL},                      // fourth digit ends escape
		'{CH_VT,     1,       '{8'h00, 1'b1, 1'b1}, NIL},     // separator closes token
		'{CH_BSLASH, PREDICT, NIL, NIL},
		'{CH_DIG0 + 8'd2, PREDICT, NIL, NIL},
		'{CH_NUL,    PREDICT, NIL, NIL},                      // NUL flushes pending octal
		'{CH_BSLASH, 0,       NIL, NIL},
		'{CH_NUL,    0,       NIL, NIL}                       // dangling escape, no end
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			offer(script[i].ch, script[i].typed_n, script[i].w0, script[i].w1);
		for (int i = 0; i < RANDOM_CHARS; i++)
			offer(pick_char(), PREDICT, NIL, NIL);
		offer(CH_NUL, PREDICT, NIL, NIL);
		in_valid <= 1'b0;

		// drain; the watchdog covers a block that never delivers
		@(posedge clk);
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: one long hold-off once random traffic runs, so the result
	// queue fills and in_stall must rise; otherwise segments of no stall,
	// coin-flip stall and a sparse periodic stall.
	// ------------------------------------------------------------------
	initial begin
		int  kind;
		int  span;
		int  tick;
		bit  held_off;
		held_off = 1'b0;
		tick     = 0;
		wait (arst_n);
		forever begin
			if (!held_off && chars_taken >= 40) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end
			kind = $urandom_range(0, 2);
			span = $urandom_range(5, 60);
			repeat (span) begin
				case (kind)
					0:       out_stall <= 1'b0;
					1:       out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= (tick % 3 == 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

endmodule

// ===== files.f =====
rtl/eat_pkg.sv
rtl/eat_step.sv
rtl/eat_queue.sv
rtl/escape_aware_tokenizer.sv
tb/testbench.sv
